// ----- rtl/dra_pkg.sv -----
// Package for the descriptor range allocator: types, codes and fixed widths.
// Used by the response channel interface, the controller, the datapath and the top level.
package dra_pkg;

    localparam int STRIDE_W    = 9;
    localparam int COUNT_W     = 11;
    localparam int STATUS_W    = 2;
    localparam int SPAN_PROD_W = STRIDE_W + COUNT_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd2;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd32;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 11'd1024;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_MUL,
        S_LOAD_WR,
        S_START,
        S_RD,
        S_EVAL,
        S_DN_RD,
        S_DN_WR,
        S_UP_RD,
        S_UP_WR,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_FRONT,
        WR_LO,
        WR_HI,
        WR_DN,
        WR_UP,
        WR_NEW
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ONE,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_LOAD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_IDX,
        POS_COUNT
    } t_pos_op;

    typedef struct packed {
        logic    accept;
        logic    load_start;
        logic    rd_en;
        logic    rd_prev;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        t_cnt_op cnt_op;
        t_pos_op pos_op;
        logic    grant_set;
        logic    st_set;
        t_status st_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic reload_pend;
        logic op_free;
        logic count_zero;
        logic count_full;
        logic idx_ge_count;
        logic next_last;
        logic idx_eq_pos;
        logic alloc_used;
        logic hit_lo;
        logic hit_hi;
        logic above_item;
        logic out_busy;
    } t_sts;

endpackage

// ----- rtl/dra_req_if.sv -----
// Request channel of the descriptor range allocator: valid, ready and request payload.
// Depends on nothing but its address width parameter.
interface dra_req_if #(
    parameter int ADDRESS_BITS = 48
) ();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [ADDRESS_BITS-1:0] slot_address;

    modport source (output valid, operation, slot_address, input ready);
    modport sink (input valid, operation, slot_address, output ready);
endinterface

// ----- rtl/dra_rsp_if.sv -----
// Response channel of the descriptor range allocator: valid, ready and result payload.
// Depends on dra_pkg for the status width.
interface dra_rsp_if #(
    parameter int ADDRESS_BITS = 48
) ();
    import dra_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ADDRESS_BITS-1:0] granted_address;
    logic [STATUS_W-1:0]     status;
    logic                    heap_empty;

    modport source (output valid, granted_address, status, heap_empty, input ready);
    modport sink (input valid, granted_address, status, heap_empty, output ready);
endinterface

// ----- rtl/dra_datapath.sv -----
// Datapath of the descriptor range allocator: configuration registers, range memory,
// walk index, range count and the output register. Depends on dra_pkg.
module dra_datapath #(
    parameter int ADDRESS_BITS = 48,
    parameter int MAX_RANGES   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dra_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ADDRESS_BITS-1:0]              i_cfg_data,
    input  logic                                 i_operation,
    input  logic [ADDRESS_BITS-1:0]              i_slot_address,
    input  dra_pkg::t_cmd                        i_cmd,
    output dra_pkg::t_sts                        o_sts,
    input  logic                                 i_rsp_ready,
    output logic                                 o_rsp_valid,
    output logic [ADDRESS_BITS-1:0]              o_granted_address,
    output logic [dra_pkg::STATUS_W-1:0]         o_status,
    output logic                                 o_heap_empty
);
    import dra_pkg::*;

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);

    logic [ADDRESS_BITS-1:0] r_heap_base;
    logic [STRIDE_W-1:0]     r_stride;
    logic [COUNT_W-1:0]      r_slot_count;
    logic                    r_pend;
    logic [ADDRESS_BITS-1:0] r_span;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_pos;
    logic                    r_op;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [ADDRESS_BITS-1:0] r_above;
    logic [ADDRESS_BITS-1:0] r_rs;
    logic [ADDRESS_BITS-1:0] r_re;
    logic [ADDRESS_BITS-1:0] r_granted;
    t_status                 r_status;
    logic                    r_out_valid;
    logic [ADDRESS_BITS-1:0] r_out_granted;
    t_status                 r_out_status;
    logic                    r_out_empty;

    logic [ADDRESS_BITS-1:0] r_mem_start [MAX_RANGES];
    logic [ADDRESS_BITS-1:0] r_mem_end   [MAX_RANGES];

    logic [ADDRESS_BITS-1:0]             stride_ext;
    logic [SPAN_PROD_W-1:0]              span_prod;
    logic [ADDRESS_BITS+SPAN_PROD_W-1:0] span_wide;
    logic [CNT_W-1:0]                    idx_m1;
    logic [CNT_W:0]                      idx_p1;
    logic [IDX_W-1:0]                    rd_addr;
    logic                                wr_en;
    logic [IDX_W-1:0]                    wr_addr;
    logic [ADDRESS_BITS-1:0]             wr_start;
    logic [ADDRESS_BITS-1:0]             wr_end;
    logic                                cfg_hit;

    assign stride_ext = {{(ADDRESS_BITS-STRIDE_W){1'b0}}, r_stride};
    assign span_prod  = SPAN_PROD_W'(r_slot_count) * SPAN_PROD_W'(r_stride);
    assign span_wide  = {{ADDRESS_BITS{1'b0}}, span_prod};
    assign idx_m1     = r_idx - 1'b1;
    assign idx_p1     = {1'b0, r_idx} + 1'b1;
    assign rd_addr    = i_cmd.rd_prev ? idx_m1[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign cfg_hit    = i_cfg_we && (i_cfg_index == CFG_HEAP_BASE ||
                                     i_cfg_index == CFG_SLOT_STRIDE ||
                                     i_cfg_index == CFG_SLOT_COUNT);

    always_comb begin
        wr_en    = 1'b1;
        wr_addr  = r_idx[IDX_W-1:0];
        wr_start = r_rs;
        wr_end   = r_re;
        case (i_cmd.wr_sel)
            WR_LOAD: begin
                wr_addr  = '0;
                wr_start = r_heap_base;
                wr_end   = r_heap_base + r_span;
            end
            WR_FRONT: begin
                wr_start = r_rs + stride_ext;
            end
            WR_LO: begin
                wr_start = r_addr;
            end
            WR_HI: begin
                wr_end = r_re + stride_ext;
            end
            WR_DN: begin
                wr_addr = idx_m1[IDX_W-1:0];
            end
            WR_UP: begin
                wr_en = 1'b1;
            end
            WR_NEW: begin
                wr_addr  = r_pos[IDX_W-1:0];
                wr_start = r_addr;
                wr_end   = r_above;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_start[wr_addr] <= wr_start;
            r_mem_end[wr_addr]   <= wr_end;
        end
        if (i_cmd.rd_en) begin
            r_rs <= r_mem_start[rd_addr];
            r_re <= r_mem_end[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_stride     <= STRIDE_RESET;
            r_slot_count <= COUNT_RESET;
            r_pend       <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAP_BASE:   r_heap_base  <= i_cfg_data;
                    CFG_SLOT_STRIDE: r_stride     <= i_cfg_data[STRIDE_W-1:0];
                    CFG_SLOT_COUNT:  r_slot_count <= i_cfg_data[COUNT_W-1:0];
                    default:         r_heap_base  <= r_heap_base;
                endcase
            end
            if (cfg_hit) begin
                r_pend <= 1'b1;
            end else if (i_cmd.load_start) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_span <= span_wide[ADDRESS_BITS-1:0];
        end
        if (i_cmd.accept) begin
            r_op    <= i_operation;
            r_addr  <= i_slot_address;
            r_above <= i_slot_address + stride_ext;
        end
        if (i_cmd.accept) begin
            r_granted <= '0;
        end else if (i_cmd.grant_set) begin
            r_granted <= r_rs;
        end
        if (i_cmd.accept) begin
            r_status <= ST_OK;
        end else if (i_cmd.st_set) begin
            r_status <= i_cmd.st_code;
        end
        case (i_cmd.pos_op)
            POS_IDX:   r_pos <= r_idx;
            POS_COUNT: r_pos <= r_count;
            default:   r_pos <= r_pos;
        endcase
        if (i_cmd.out_load) begin
            r_out_granted <= r_granted;
            r_out_status  <= r_status;
            r_out_empty   <= (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_LOAD: r_count <= (r_span != '0) ? CNT_W'(1) : '0;
                CNT_INC:  r_count <= r_count + 1'b1;
                CNT_DEC:  r_count <= r_count - 1'b1;
                default:  r_count <= r_count;
            endcase
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else begin
                case (i_cmd.idx_op)
                    IDX_ONE:   r_idx <= CNT_W'(1);
                    IDX_INC:   r_idx <= idx_p1[CNT_W-1:0];
                    IDX_DEC:   r_idx <= idx_m1;
                    IDX_COUNT: r_idx <= r_count;
                    default:   r_idx <= r_idx;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.reload_pend  = r_pend;
        o_sts.op_free      = r_op;
        o_sts.count_zero   = (r_count == '0);
        o_sts.count_full   = (r_count == MAX_CNT);
        o_sts.idx_ge_count = (r_idx >= r_count);
        o_sts.next_last    = (idx_p1 >= {1'b0, r_count});
        o_sts.idx_eq_pos   = (r_idx == r_pos);
        o_sts.alloc_used   = ((r_rs + stride_ext) == r_re);
        o_sts.hit_lo       = (r_rs == r_above);
        o_sts.hit_hi       = (r_re == r_addr);
        o_sts.above_item   = (r_rs > r_addr);
        o_sts.out_busy     = r_out_valid && !i_rsp_ready;
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_granted_address = r_out_granted;
    assign o_status          = r_out_status;
    assign o_heap_empty      = r_out_empty;

endmodule

// ----- rtl/dra_controller.sv -----
// Controller of the descriptor range allocator: sequences reloads, range walks and
// table shifts through datapath commands. Depends on dra_pkg.
module dra_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  dra_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output dra_pkg::t_cmd o_cmd
);
    import dra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_sts.reload_pend) begin
                    n_state = S_LOAD_MUL;
                end else if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_LOAD_MUL: n_state = S_LOAD_WR;
            S_LOAD_WR:  n_state = S_IDLE;
            S_START: begin
                if (!i_sts.count_zero) begin
                    n_state = S_RD;
                end else if (i_sts.op_free) begin
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: begin
                if (!i_sts.op_free) begin
                    n_state = i_sts.alloc_used ? S_DN_RD : S_DONE;
                end else if (i_sts.hit_lo || i_sts.hit_hi) begin
                    n_state = S_DONE;
                end else if (i_sts.above_item || i_sts.next_last) begin
                    n_state = i_sts.count_full ? S_DONE : S_UP_RD;
                end else begin
                    n_state = S_RD;
                end
            end
            S_DN_RD: n_state = i_sts.idx_ge_count ? S_DONE : S_DN_WR;
            S_DN_WR: n_state = S_DN_RD;
            S_UP_RD: n_state = i_sts.idx_eq_pos ? S_DONE : S_UP_WR;
            S_UP_WR: n_state = S_UP_RD;
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{
            accept:     1'b0,
            load_start: 1'b0,
            rd_en:      1'b0,
            rd_prev:    1'b0,
            wr_sel:     WR_NONE,
            idx_op:     IDX_HOLD,
            cnt_op:     CNT_HOLD,
            pos_op:     POS_HOLD,
            grant_set:  1'b0,
            st_set:     1'b0,
            st_code:    ST_OK,
            out_load:   1'b0
        };
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_sts.reload_pend;
                if (i_sts.reload_pend) begin
                    o_cmd.load_start = 1'b1;
                end else if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                end
            end
            S_LOAD_WR: begin
                o_cmd.wr_sel = WR_LOAD;
                o_cmd.cnt_op = CNT_LOAD;
            end
            S_START: begin
                if (i_sts.count_zero) begin
                    if (i_sts.op_free) begin
                        o_cmd.pos_op = POS_COUNT;
                        o_cmd.idx_op = IDX_COUNT;
                    end else begin
                        o_cmd.st_set  = 1'b1;
                        o_cmd.st_code = ST_EMPTY;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_EVAL: begin
                if (!i_sts.op_free) begin
                    o_cmd.grant_set = 1'b1;
                    if (i_sts.alloc_used) begin
                        o_cmd.idx_op = IDX_ONE;
                    end else begin
                        o_cmd.wr_sel = WR_FRONT;
                    end
                end else if (i_sts.hit_lo) begin
                    o_cmd.wr_sel = WR_LO;
                end else if (i_sts.hit_hi) begin
                    o_cmd.wr_sel = WR_HI;
                end else if (i_sts.above_item || i_sts.next_last) begin
                    if (i_sts.count_full) begin
                        o_cmd.st_set  = 1'b1;
                        o_cmd.st_code = ST_FULL;
                    end else begin
                        o_cmd.pos_op = i_sts.above_item ? POS_IDX : POS_COUNT;
                        o_cmd.idx_op = IDX_COUNT;
                    end
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_DN_RD: begin
                if (i_sts.idx_ge_count) begin
                    o_cmd.cnt_op = CNT_DEC;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_sel = WR_DN;
                o_cmd.idx_op = IDX_INC;
            end
            S_UP_RD: begin
                if (i_sts.idx_eq_pos) begin
                    o_cmd.wr_sel = WR_NEW;
                    o_cmd.cnt_op = CNT_INC;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_prev = 1'b1;
                end
            end
            S_UP_WR: begin
                o_cmd.wr_sel = WR_UP;
                o_cmd.idx_op = IDX_DEC;
            end
            S_DONE: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/descriptor_range_allocator.sv -----
// Descriptor range allocator: keeps an ordered table of up to MAX_RANGES free slot
// ranges in a single-port memory and serves allocate and free requests one at a time,
// one response beat per request beat. The walk over the table and the shift that
// inserts or drops a range read the range memory through one registered read port,
// each entry read before it is evaluated or written. A response is loaded only once
// the previous one has been taken, and the next request is taken only when the
// controller is back in its idle state. Reset and every write to the heap base, slot
// stride or slot count register reload the table as one range over the whole heap
// (an empty table when that span is zero); no request is taken meanwhile. A finished
// response waits in an output register while the next request is already being
// worked on. Depends on dra_pkg, dra_req_if, dra_rsp_if, dra_controller and
// dra_datapath.
module descriptor_range_allocator #(
    parameter int ADDRESS_BITS = 48,
    parameter int MAX_RANGES   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDRESS_BITS-1:0]       i_cfg_data,
    dra_req_if.sink                       i_req,
    dra_rsp_if.source                     o_rsp
);
    import dra_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    dra_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    dra_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .MAX_RANGES   (MAX_RANGES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_operation       (i_req.operation),
        .i_slot_address    (i_req.slot_address),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_granted_address (o_rsp.granted_address),
        .o_status          (o_rsp.status),
        .o_heap_empty      (o_rsp.heap_empty)
    );

    assign i_req.ready = in_ready;

    a_ready_no_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !sts.reload_pend)
        else $error("request taken while a table reload is pending");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> !o_rsp.heap_empty)
        else $error("table full reported together with an empty heap");

    a_empty_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |->
            (o_rsp.granted_address == '0 && o_rsp.heap_empty))
        else $error("empty response carries an address or a nonempty heap");

    a_single_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_rsp.valid && !o_rsp.ready))
        else $error("response register overwritten before its beat was taken");

endmodule

// ----- dv/descriptor_range_allocator_test.sv -----
// Self-checking test of descriptor_range_allocator: directed and random allocate and free
// beats, checked field by field against a free-range table kept beside the block.
// Depends on dra_pkg, dra_req_if, dra_rsp_if and the block itself.
`timescale 1ns / 1ps

module descriptor_range_allocator_test;
    import dra_pkg::*;

    localparam int ADDR_W      = 48;
    localparam int RANGE_SLOTS = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum bit {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_req_op;

    typedef struct {
        bit [ADDR_W-1:0] granted;
        t_status         status;
        bit              empty;
    } t_reply;

    class free_range_tracker;
        bit [ADDR_W-1:0]   base;
        bit [STRIDE_W-1:0] stride;
        bit [COUNT_W-1:0]  slots;
        bit [ADDR_W-1:0]   starts[RANGE_SLOTS];
        bit [ADDR_W-1:0]   ends[RANGE_SLOTS];
        int unsigned       count;
        t_reply            awaited_replies[$];
        int unsigned       error_count;

        function new();
            base        = '0;
            stride      = STRIDE_RESET;
            slots       = COUNT_RESET;
            error_count = 0;
            reload();
        endfunction

        function void reload();
            bit [ADDR_W-1:0] span;
            span = ADDR_W'(slots) * ADDR_W'(stride);
            foreach (starts[i]) begin
                starts[i] = '0;
                ends[i]   = '0;
            end
            if (span == '0) begin
                count = 0;
            end else begin
                starts[0] = base;
                ends[0]   = base + span;
                count     = 1;
            end
        endfunction

        function bit write_register(logic [CFG_IDX_W-1:0] idx, bit [ADDR_W-1:0] data);
            case (idx)
                CFG_HEAP_BASE: begin
                    base = data;
                end
                CFG_SLOT_STRIDE: begin
                    stride = data[STRIDE_W-1:0];
                end
                CFG_SLOT_COUNT: begin
                    slots = data[COUNT_W-1:0];
                end
                default: begin
                    return 1'b0;
                end
            endcase
            reload();
            return 1'b1;
        endfunction

        function bit insert_range(int unsigned pos, bit [ADDR_W-1:0] addr);
            if (count >= RANGE_SLOTS) return 1'b0;
            for (int i = count; i > pos; i--) begin
                starts[i] = starts[i-1];
                ends[i]   = ends[i-1];
            end
            starts[pos] = addr;
            ends[pos]   = addr + ADDR_W'(stride);
            count++;
            return 1'b1;
        endfunction

        function t_reply take_request(t_req_op op, bit [ADDR_W-1:0] addr);
            t_reply          r;
            bit [ADDR_W-1:0] above;
            bit              done;
            r.granted = '0;
            r.status  = ST_OK;
            done      = 1'b0;
            if (op == OP_ALLOC) begin
                if (count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.granted = starts[0];
                    starts[0] = starts[0] + ADDR_W'(stride);
                    if (starts[0] == ends[0]) begin
                        for (int i = 1; i < count; i++) begin
                            starts[i-1] = starts[i];
                            ends[i-1]   = ends[i];
                        end
                        count--;
                    end
                end
            end else begin
                above = addr + ADDR_W'(stride);
                for (int i = 0; i < count && !done; i++) begin
                    if (starts[i] == above) begin
                        starts[i] = addr;
                        done = 1'b1;
                    end else if (ends[i] == addr) begin
                        ends[i] = ends[i] + ADDR_W'(stride);
                        done = 1'b1;
                    end else if (starts[i] > addr) begin
                        if (!insert_range(i, addr)) r.status = ST_FULL;
                        done = 1'b1;
                    end
                end
                if (!done && !insert_range(count, addr)) r.status = ST_FULL;
            end
            r.empty = (count == 0);
            awaited_replies.insert(awaited_replies.size(), r);
            return r;
        endfunction

        function void match_reply(logic [ADDR_W-1:0] granted, logic [STATUS_W-1:0] status,
                                  logic empty);
            t_reply r;
            if (awaited_replies.size() == 0) begin
                $error("response beat arrived with no request outstanding");
                error_count++;
                return;
            end
            r = awaited_replies[0];
            awaited_replies.delete(0);
            if (granted !== r.granted) begin
                $error("granted_address expected %h actual %h", r.granted, granted);
                error_count++;
            end
            if (status !== r.status) begin
                $error("status expected %0d actual %0d", r.status, status);
                error_count++;
            end
            if (empty !== r.empty) begin
                $error("heap_empty expected %0d actual %0d", r.empty, empty);
                error_count++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;

    dra_req_if #(.ADDRESS_BITS(ADDR_W)) req_ch ();
    dra_rsp_if #(.ADDRESS_BITS(ADDR_W)) rsp_ch ();

    free_range_tracker sb;
    bit [ADDR_W-1:0]   held_slots[$];
    int unsigned       cycle_count = 0;
    int unsigned       stall_left  = 0;
    int unsigned       window_left = 0;
    bit                rsp_steady  = 1'b0;

    descriptor_range_allocator #(
        .ADDRESS_BITS(ADDR_W),
        .MAX_RANGES  (RANGE_SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic bit [ADDR_W-1:0] rand48();
        bit [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (window_left == 0) begin
            window_left <= $urandom_range(50, 300);
            rsp_steady  <= ($urandom_range(0, 2) == 0);
        end else begin
            window_left <= window_left - 1;
        end
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (!rsp_steady && $urandom_range(0, 3) == 0) begin
            stall_left   <= idle_len() - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            sb.match_reply(rsp_ch.granted_address, rsp_ch.status, rsp_ch.heap_empty);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(t_req_op op, bit [ADDR_W-1:0] addr, int unsigned gap);
        t_reply r;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.slot_address <= addr;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        r = sb.take_request(op, addr);
        if (op == OP_ALLOC && r.status == ST_OK) begin
            held_slots.insert(held_slots.size(), r.granted);
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.awaited_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit [ADDR_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (sb.write_register(idx, data)) held_slots.delete();
    endtask

    task automatic configure(bit [ADDR_W-1:0] base, bit [ADDR_W-1:0] stride,
                             bit [ADDR_W-1:0] count);
        settle();
        cfg_write(CFG_HEAP_BASE, base);
        cfg_write(CFG_SLOT_STRIDE, stride);
        cfg_write(CFG_SLOT_COUNT, count);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(int unsigned n);
        int unsigned     sent;
        int unsigned     burst;
        int unsigned     kind;
        int unsigned     pick;
        bit              steady;
        t_req_op         op;
        bit [ADDR_W-1:0] addr;
        sent = 0;
        while (sent < n) begin
            kind   = $urandom_range(0, 9);
            burst  = $urandom_range(1, 24);
            steady = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                addr = rand48();
                case (kind)
                    0, 1, 2, 3: op = OP_ALLOC;
                    4, 5, 6, 7: op = (held_slots.size() != 0) ? OP_FREE : OP_ALLOC;
                    default:    op = t_req_op'($urandom_range(0, 1));
                endcase
                if (op == OP_FREE && kind <= 7) begin
                    pick = $urandom_range(0, held_slots.size() - 1);
                    addr = held_slots[pick];
                    held_slots.delete(pick);
                end else if (op == OP_FREE && $urandom_range(0, 1) == 0) begin
                    addr = sb.base + ADDR_W'(sb.stride) * ADDR_W'($urandom_range(0, 2 * sb.slots));
                end
                send_request(op, addr,
                             (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_data          <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= 1'b0;
        req_ch.slot_address <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_ALLOC, '0, 0);
        send_request(OP_ALLOC, '0, 1);
        send_request(OP_ALLOC, '0, 0);
        send_request(OP_FREE, 48'h0, 0);
        send_request(OP_FREE, 48'h20, 0);
        send_request(OP_FREE, 48'h40, 2);
        send_request(OP_ALLOC, 48'hFFFF_FFFF_FFFF, 0);
        send_request(OP_FREE, 48'hFFFF_FFFF_FFFF, 0);
        send_request(OP_FREE, 48'h5, 0);
        send_request(OP_FREE, 48'h28, 0);
        send_request(OP_FREE, 48'h0, 0);
        send_request(OP_FREE, 48'hAAAA_AAAA_AAAA, 0);
        send_request(OP_FREE, 48'h5555_5555_5555, 3);
        send_request(OP_ALLOC, 48'h5555_5555_5555, 0);
        send_request(OP_ALLOC, '0, 0);

        configure(48'h100, 48'h0, 48'h10);
        send_request(OP_ALLOC, '0, 0);
        send_request(OP_FREE, 48'h200, 0);
        send_request(OP_ALLOC, '0, 0);
        send_request(OP_ALLOC, '0, 0);
        configure(48'h0, 48'h20, 48'h0);
        send_request(OP_ALLOC, '0, 0);
        send_request(OP_FREE, 48'h40, 0);
        send_request(OP_ALLOC, '0, 0);

        configure(48'h1000, 48'd16, 48'd48);
        random_traffic(120);
        configure(48'hFFFF_FFFF_FF80, 48'd256, 48'd3);
        random_traffic(90);
        configure(rand48(), 48'd1, 48'd1);
        random_traffic(80);
        configure(48'hFFFF_FFFF_FFFF, 48'd256, 48'd1024);
        random_traffic(140);
        configure(rand48(), 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        random_traffic(120);
        settle();
        cfg_write(CFG_SPARE, rand48());
        i_cfg_we <= 1'b0;
        random_traffic(100);
        configure(48'h20_0000, 48'd8, 48'd40);
        random_traffic(160);
        settle();
        cfg_write(CFG_SLOT_STRIDE, 48'h0);
        i_cfg_we <= 1'b0;
        random_traffic(50);

        settle();
        repeat (50) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
